>>> rtl/byte_memory_24bit_word_access_macros.svh
// assertion macros for the byte memory block
`ifndef BYTE_MEMORY_24BIT_WORD_ACCESS_MACROS_SVH
`define BYTE_MEMORY_24BIT_WORD_ACCESS_MACROS_SVH

`ifndef SYNTHESIS

`define BMW_ASSERT(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("bmw check failed");

`define BMW_ASSERT_NEXT(name, trig, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error("bmw check failed");

`else

`define BMW_ASSERT(name, cond)

`define BMW_ASSERT_NEXT(name, trig, cond)

`endif

`endif

>>> rtl/bmw_pkg.sv
`timescale 1ns / 1ps

package bmw_pkg;

  typedef enum logic [2:0] {
    OP_RD_BYTE = 3'd0,
    OP_RD_WORD = 3'd1,
    OP_WR_BYTE = 3'd2,
    OP_WR_WORD = 3'd3,
    OP_LOAD    = 3'd4
  } opcode_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [14:0]        address;
    logic signed [23:0] write_value;
    logic [7:0]         hex_high;
    logic [7:0]         hex_low;
    logic               record_start;
    logic               record_last;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] read_value;
    logic               record_done;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rd_en;
    logic wr_en;
    logic shift;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rd;
    logic wr;
    logic word;
  } status_t;

endpackage

>>> rtl/bmw_datapath.sv
`timescale 1ns / 1ps

module bmw_datapath #(
  parameter int unsigned MEM_BYTES = 32768
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bmw_pkg::in_item_t  in_data_i,
  input  bmw_pkg::cmd_t      cmd_i,
  output bmw_pkg::status_t   status_o,
  output bmw_pkg::out_item_t out_data_o
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam int RW = AW + 16;
  localparam int SH = (AW >= 15) ? 0 : 15 - AW;

  logic [7:0]    mem [MEM_BYTES];

  logic [2:0]    op_q;
  logic [AW-1:0] ptr_q;
  logic [AW-1:0] lp_q;
  logic [23:0]   wbuf_q;
  logic [23:0]   acc_q;
  logic [7:0]    rdata_q;
  logic          last_q;

  logic [RW-1:0] red;
  logic [AW-1:0] addr_red;
  logic [AW-1:0] ptr_next;
  logic [7:0]    hv_hi;
  logic [7:0]    hv_lo;
  logic [7:0]    hex_byte;

  function automatic logic [7:0] hex_val(input logic [7:0] ch);
    return (ch >= 8'd65) ? ch - 8'd55 : ch - 8'd48;
  endfunction

  // address modulo memory size by conditional subtraction
  always_comb begin
    red = RW'(in_data_i.address);
    for (int i = SH; i >= 0; i--) begin
      if (red >= (RW'(MEM_BYTES) << i)) begin
        red = red - (RW'(MEM_BYTES) << i);
      end
    end
  end

  assign addr_red = red[AW-1:0];
  assign ptr_next = (ptr_q == AW'(MEM_BYTES - 1)) ? '0 : ptr_q + AW'(1);
  assign hv_hi    = hex_val(in_data_i.hex_high);
  assign hv_lo    = hex_val(in_data_i.hex_low);
  assign hex_byte = (hv_hi << 4) + hv_lo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q <= '0;
    end else if (cmd_i.wr_en && op_q == bmw_pkg::OP_LOAD) begin
      lp_q <= ptr_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= in_data_i.opcode;
      acc_q  <= '0;
      last_q <= (in_data_i.opcode == bmw_pkg::OP_LOAD) && in_data_i.record_last;
      if (in_data_i.opcode == bmw_pkg::OP_LOAD && !in_data_i.record_start) begin
        ptr_q <= lp_q;
      end else begin
        ptr_q <= addr_red;
      end
      case (in_data_i.opcode)
        bmw_pkg::OP_WR_BYTE: wbuf_q <= {in_data_i.write_value[7:0], 16'h0000};
        bmw_pkg::OP_LOAD:    wbuf_q <= {hex_byte, 16'h0000};
        default:             wbuf_q <= in_data_i.write_value;
      endcase
    end else begin
      if (cmd_i.rd_en || cmd_i.wr_en) begin
        ptr_q <= ptr_next;
      end
      if (cmd_i.wr_en) begin
        wbuf_q <= {wbuf_q[15:0], 8'h00};
      end
      if (cmd_i.shift) begin
        acc_q <= {acc_q[15:0], rdata_q};
      end
    end
  end

  // byte-wide memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[ptr_q] <= wbuf_q[23:16];
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[ptr_q];
    end
  end

  assign status_o.rd   = (op_q == bmw_pkg::OP_RD_BYTE) || (op_q == bmw_pkg::OP_RD_WORD);
  assign status_o.wr   = (op_q == bmw_pkg::OP_WR_BYTE) || (op_q == bmw_pkg::OP_WR_WORD)
                         || (op_q == bmw_pkg::OP_LOAD);
  assign status_o.word = (op_q == bmw_pkg::OP_RD_WORD) || (op_q == bmw_pkg::OP_WR_WORD);

  assign out_data_o.read_value  = $signed(acc_q);
  assign out_data_o.record_done = last_q;

endmodule

>>> rtl/bmw_ctrl.sv
`timescale 1ns / 1ps

`include "byte_memory_24bit_word_access_macros.svh"

module bmw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  bmw_pkg::status_t status_i,
  output bmw_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } state_e;

  state_e     state_q;
  logic [1:0] cnt_q;
  logic       out_valid_q;
  logic [1:0] nbytes;
  logic       finish;

  assign nbytes = status_i.word ? 2'd3 : 2'd1;

  always_comb begin
    cmd_o       = '0;
    finish      = 1'b0;
    cmd_o.load  = in_valid_i && (state_q == ST_IDLE);
    if (state_q == ST_RUN) begin
      if (status_i.rd) begin
        cmd_o.rd_en = cnt_q < nbytes;
        cmd_o.shift = cnt_q != 2'd0;
        finish      = cnt_q == nbytes;
      end else if (status_i.wr) begin
        cmd_o.wr_en = 1'b1;
        finish      = cnt_q == nbytes - 2'd1;
      end else begin
        finish      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_RUN;
            cnt_q   <= '0;
          end
        end
        ST_RUN: begin
          if (finish) begin
            state_q     <= ST_OUT;
            out_valid_q <= 1'b1;
          end else begin
            cnt_q <= cnt_q + 2'd1;
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q     <= ST_IDLE;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

  `BMW_ASSERT(a_no_rd_wr_together, !(cmd_o.rd_en && cmd_o.wr_en))
  `BMW_ASSERT(a_shift_only_on_read, !cmd_o.shift || status_i.rd)
  `BMW_ASSERT(a_out_blocks_in, !out_valid_o || !in_ready_o)
  `BMW_ASSERT_NEXT(a_accept_busy, in_valid_i && in_ready_o, !in_ready_o && !out_valid_o)

endmodule

>>> rtl/byte_memory_24bit_word_access.sv
// channel | signals                          | payload
// in      | in_valid_i, in_ready_o           | in_data_i  (bmw_pkg::in_item_t)
// out     | out_valid_o, out_ready_i         | out_data_o (bmw_pkg::out_item_t)
//
// one item at a time; the byte-wide memory port moves one byte per cycle
// byte read and write move one byte, word read and write three, load one byte;
// unused opcodes move no byte and only return a result
// in_ready_o stays low from acceptance until the result is taken on out_ready_i
// reset clears the controller and the load pointer; memory contents are not cleared
`timescale 1ns / 1ps

module byte_memory_24bit_word_access #(
  parameter int unsigned MEM_BYTES = 32768
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bmw_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bmw_pkg::out_item_t out_data_o
);

  bmw_pkg::cmd_t    cmd;
  bmw_pkg::status_t status;

  bmw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bmw_datapath #(
    .MEM_BYTES (MEM_BYTES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bmw_pkg::*;

  localparam int unsigned MEM_SIZE = 32768;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned ITEMS_PER_PHASE = 417;
  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  byte_memory_24bit_word_access u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // stimulus and scoreboard state
  in_item_t    access_q[$];
  out_item_t   due_results[$];
  logic        in_fire = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles = 0;
  int          errors = 0;

  // memory image used for prediction
  logic [7:0]  mem_image [MEM_SIZE];
  int unsigned load_ptr = 0;

  // generator view: which cells hold data, where loads will land
  bit          written [MEM_SIZE];
  int unsigned written_addrs[$];
  int unsigned gen_ptr = 0;
  int unsigned gen_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned hex_digit(logic [7:0] ch);
    return (ch >= 8'd65) ? (int'(ch) - 55) : (int'(ch) - 48);
  endfunction

  function automatic out_item_t apply_access(in_item_t it);
    out_item_t   res;
    int unsigned a;
    int unsigned packed_byte;
    res = '0;
    a = it.address;
    case (it.opcode)
      OP_RD_BYTE: res.read_value = {16'h0000, mem_image[a]};
      OP_RD_WORD: res.read_value = {mem_image[a], mem_image[(a + 1) % MEM_SIZE],
                                    mem_image[(a + 2) % MEM_SIZE]};
      OP_WR_BYTE: mem_image[a] = it.write_value[7:0];
      OP_WR_WORD: begin
        mem_image[a] = it.write_value[23:16];
        mem_image[(a + 1) % MEM_SIZE] = it.write_value[15:8];
        mem_image[(a + 2) % MEM_SIZE] = it.write_value[7:0];
      end
      OP_LOAD: begin
        if (it.record_start) load_ptr = a;
        packed_byte = (hex_digit(it.hex_high) << 4) + hex_digit(it.hex_low);
        mem_image[load_ptr] = packed_byte[7:0];
        load_ptr = (load_ptr + 1) % MEM_SIZE;
        res.record_done = it.record_last;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void mark_written(int unsigned a);
    if (!written[a]) begin
      written[a] = 1'b1;
      written_addrs.push_back(a);
    end
  endfunction

  function automatic bit word_ready(int unsigned a);
    return written[a] && written[(a + 1) % MEM_SIZE] && written[(a + 2) % MEM_SIZE];
  endfunction

  function automatic void queue_access(in_item_t it);
    int unsigned a;
    a = it.address;
    case (it.opcode)
      OP_WR_BYTE: mark_written(a);
      OP_WR_WORD: begin
        mark_written(a);
        mark_written((a + 1) % MEM_SIZE);
        mark_written((a + 2) % MEM_SIZE);
      end
      OP_LOAD: begin
        if (it.record_start) gen_ptr = a;
        mark_written(gen_ptr);
        gen_ptr = (gen_ptr + 1) % MEM_SIZE;
      end
      default: ;
    endcase
    access_q.push_back(it);
    gen_count++;
  endfunction

  function automatic in_item_t make_access(logic [2:0] op, logic [14:0] addr,
                                           logic [23:0] wval, logic [7:0] hi,
                                           logic [7:0] lo, logic rs, logic rl);
    in_item_t it;
    it.opcode       = op;
    it.address      = addr;
    it.write_value  = wval;
    it.hex_high     = hi;
    it.hex_low      = lo;
    it.record_start = rs;
    it.record_last  = rl;
    return it;
  endfunction

  function automatic in_item_t random_access();
    in_item_t it;
    it.opcode       = 3'($urandom);
    it.address      = 15'($urandom);
    it.write_value  = 24'($urandom);
    it.hex_high     = 8'($urandom);
    it.hex_low      = 8'($urandom);
    it.record_start = 1'($urandom);
    it.record_last  = 1'($urandom);
    return it;
  endfunction

  function automatic logic [14:0] pick_addr();
    if ($urandom_range(0, 9) == 0) return 15'($urandom_range(MEM_SIZE - 3, MEM_SIZE - 1));
    return 15'($urandom_range(0, MEM_SIZE - 1));
  endfunction

  function automatic logic [7:0] hex_char();
    string digits;
    digits = "0123456789ABCDEFabcdef";
    return digits[$urandom_range(0, digits.len() - 1)];
  endfunction

  task automatic queue_directed();
    in_item_t it;
    // load before any record start uses the reset pointer
    queue_access(make_access(OP_LOAD, 15'd0, 24'h0, "1", "2", 1'b0, 1'b0));
    queue_access(make_access(OP_RD_BYTE, 15'd0, 24'h0, 8'h00, 8'h00, 1'b0, 1'b0));
    queue_access(make_access(OP_WR_WORD, 15'd0, 24'h7FFFFF, 8'h00, 8'h00, 1'b0, 1'b0));
    queue_access(make_access(OP_RD_WORD, 15'd0, 24'h0, 8'h00, 8'h00, 1'b0, 1'b0));
    // word at the top wraps to the bottom
    queue_access(make_access(OP_WR_WORD, 15'h7FFF, 24'h800000, 8'h00, 8'h00, 1'b0, 1'b0));
    queue_access(make_access(OP_RD_WORD, 15'h7FFF, 24'h0, 8'h00, 8'h00, 1'b0, 1'b0));
    queue_access(make_access(OP_RD_WORD, 15'd0, 24'h0, 8'h00, 8'h00, 1'b0, 1'b0));
    queue_access(make_access(OP_RD_BYTE, 15'h7FFF, 24'h0, 8'h00, 8'h00, 1'b0, 1'b0));
    // load flags and hex chars on other opcodes are ignored
    queue_access(make_access(OP_WR_BYTE, 15'h4000, 24'hFFFFFF, "Z", "z", 1'b1, 1'b1));
    queue_access(make_access(OP_RD_BYTE, 15'h4000, 24'hFFFFFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
    // record across the top of memory, odd characters included
    queue_access(make_access(OP_LOAD, 15'h7FFE, 24'h0, "0", "0", 1'b1, 1'b0));
    queue_access(make_access(OP_LOAD, 15'h1234, 24'h0, "9", "F", 1'b0, 1'b0));
    queue_access(make_access(OP_LOAD, 15'h0000, 24'h0, "A", "f", 1'b0, 1'b0));
    queue_access(make_access(OP_LOAD, 15'h7FFF, 24'h0, 8'hFF, 8'hFF, 1'b0, 1'b1));
    queue_access(make_access(OP_LOAD, 15'h0000, 24'h0, 8'h00, 8'h00, 1'b0, 1'b1));
    queue_access(make_access(OP_RD_WORD, 15'h7FFE, 24'h0, 8'h00, 8'h00, 1'b0, 1'b0));
    queue_access(make_access(OP_RD_WORD, 15'h0000, 24'h0, 8'h00, 8'h00, 1'b0, 1'b0));
    for (int op = OP_RSVD_LO; op <= OP_RSVD_HI; op++) begin
      it = random_access();
      it.opcode = 3'(op);
      queue_access(it);
    end
    queue_access(make_access(OP_LOAD, 15'h0000, 24'h0, "7", "e", 1'b1, 1'b0));
    queue_access(make_access(OP_RD_BYTE, 15'h0000, 24'h0, 8'h00, 8'h00, 1'b0, 1'b0));
    queue_access(make_access(OP_WR_BYTE, 15'h7FFF, 24'h800000, 8'h00, 8'h00, 1'b0, 1'b0));
    queue_access(make_access(OP_RD_BYTE, 15'h7FFF, 24'h0, 8'h00, 8'h00, 1'b0, 1'b0));
  endtask

  task automatic queue_random(int unsigned count);
    in_item_t    it;
    int unsigned first;
    int unsigned roll;
    int unsigned len;
    int unsigned cand;
    bit          with_start;
    bit          found;
    first = gen_count;
    while (gen_count - first < count) begin
      roll = $urandom_range(0, 99);
      it = random_access();
      if (roll < 25) begin
        len = $urandom_range(1, 8);
        with_start = ($urandom_range(0, 4) != 0);
        for (int unsigned i = 0; i < len; i++) begin
          it = random_access();
          it.opcode = OP_LOAD;
          if (i == 0) it.address = pick_addr();
          if ($urandom_range(0, 9) != 0) begin
            it.hex_high = hex_char();
            it.hex_low  = hex_char();
          end
          it.record_start = (i == 0) && with_start;
          it.record_last  = (i == len - 1);
          queue_access(it);
        end
      end else if (roll < 45) begin
        it.opcode = OP_WR_WORD;
        it.address = pick_addr();
        queue_access(it);
      end else if (roll < 60) begin
        it.opcode = OP_WR_BYTE;
        it.address = pick_addr();
        queue_access(it);
      end else if (roll < 95) begin
        found = 1'b0;
        if (roll < 80) begin
          for (int t = 0; t < 8 && !found; t++) begin
            cand = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
            found = word_ready(cand);
          end
        end
        if (found) begin
          it.opcode = OP_RD_WORD;
          it.address = 15'(cand);
        end else begin
          it.opcode = OP_RD_BYTE;
          it.address = 15'(written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
        end
        queue_access(it);
      end else begin
        // stray opcodes and loads with arbitrary characters and flags
        if ($urandom_range(0, 1) != 0) begin
          it.opcode = OP_LOAD;
        end else begin
          it.opcode = 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
        end
        queue_access(it);
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (access_q.size() != 0 || in_valid_i || due_results.size() != 0);
  endtask

  // input driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (access_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data_i  <= access_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // accepted accesses update the memory image
  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) due_results.push_back(apply_access(in_data_i));
  end

  // result monitor
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_results.size() == 0) begin
        $error("unexpected result transfer: read_value %0h record_done %0b",
               out_data_o.read_value, out_data_o.record_done);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (out_data_o.read_value !== want.read_value) begin
          $error("read_value: expected %0h, got %0h", want.read_value,
                 out_data_o.read_value);
          errors++;
        end
        if (out_data_o.record_done !== want.record_done) begin
          $error("record_done: expected %0b, got %0b", want.record_done,
                 out_data_o.record_done);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 36;
    recv_idle_pct = 69;
    queue_directed();
    queue_random(ITEMS_PER_PHASE - gen_count);
    wait_idle();

    // sender holds off until every result is back, then roles swap
    send_idle_pct = 69;
    recv_idle_pct = 36;
    queue_random(ITEMS_PER_PHASE);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(ITEMS_PER_PHASE);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && due_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
